// ===== rtl/core/dhz_pkg.sv =====
package dhz_pkg;

    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    // remainder width covers 255 * (4 * 255) for the transmission divide
    localparam int DIV_W     = 18;
    localparam int QUO_W     = 8;
    // each divider stage resolves two quotient bits
    localparam int DIV_STEPS = QUO_W / 2;

    localparam logic [CH_W-1:0] AIR_RESET = 8'd255;
    localparam logic [CH_W-1:0] PIX_MAX   = 8'd255;
    // t8 at or below this value means t below 0.1, factor fixed at 10
    localparam logic [CH_W-1:0] LOW_T_MAX = 8'd25;

    typedef enum logic [0:0] {
        REG_EST_AIR    = 1'b0,
        REG_SMOOTH_AIR = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CH_W-1:0] chan_zero;
        logic [CH_W-1:0] chan_one;
        logic [CH_W-1:0] chan_two;
        logic [CH_W-1:0] dark_value;
    } pix_t;

    typedef struct packed {
        logic [CH_W-1:0] out_zero;
        logic [CH_W-1:0] out_one;
        logic [CH_W-1:0] out_two;
        logic [CH_W-1:0] transmission;
    } res_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } div_t;

endpackage

// ===== rtl/core/dehaze_pixel_recovery.sv =====
// Per-pixel dark-channel-prior recovery. Each item carries three 8-bit colour
// channels and the filtered dark value; the result carries the three dehazed
// channels and the 8-bit transmission t8 = floor(255*(Ae - 0.75*d)/Ae), with
// t8 = 255 when Ae is 0 and t8 = 0 when 3*d >= 4*Ae. Channels are
// |(I - As)*255/t8 + As| truncated and clamped to 255, using a factor of 10
// when t8 <= 25. The block takes one item per clock while the output is not
// stalled. The pipeline holds two 8-bit restoring dividers (transmission,
// then the three channel divides side by side), each laid out as four stages
// of two quotient bits. Stalls back up stage by stage, so empty stages fill
// before pix_stall rises. Both airlight registers reset to 255 and are to be
// written only while no item is in flight.
module dehaze_pixel_recovery (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  dhz_pkg::pix_t     pix,
    output logic              res_valid,
    input  logic              res_stall,
    output dhz_pkg::res_t     res,
    input  logic              cfg_we,
    input  dhz_pkg::cfg_reg_t cfg_addr,
    input  logic [7:0]        cfg_data
);
    import dhz_pkg::*;

    localparam int S_TDIV     = 1;
    localparam int S_MIX      = S_TDIV + DIV_STEPS + 1;
    localparam int S_RDIV     = S_MIX + 1;
    localparam int S_OUT      = S_RDIV + DIV_STEPS + 1;
    localparam int NUM_STAGES = S_OUT + 1;

    typedef logic [NUM_CH-1:0][CH_W-1:0] chans_t;
    typedef div_t [NUM_CH-1:0]           div_lanes_t;

    typedef struct packed {
        chans_t           chans;
        logic             ae_zero;
        logic             num_le0;
        logic [DIV_W-1:0] dsh;
    } tside_t;

    typedef struct packed {
        logic [NUM_CH-1:0][CH_W:0] diff;
        logic [2*CH_W-1:0]         prod;
        logic [CH_W-1:0]           t8;
    } mix_t;

    typedef struct packed {
        logic [CH_W-1:0]           t8;
        logic                      low;
        logic [NUM_CH-1:0]         sat;
        logic [NUM_CH-1:0][CH_W-1:0] lowv;
        logic [DIV_W-1:0]          dsh;
    } rside_t;

    // configuration
    logic [CH_W-1:0] est_air_reg;
    logic [CH_W-1:0] smooth_air_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_air_reg    <= AIR_RESET;
            smooth_air_reg <= AIR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_EST_AIR:    est_air_reg    <= cfg_data;
                REG_SMOOTH_AIR: smooth_air_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // stage control
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES:0]   rdy;

    always_comb
    begin
        rdy[NUM_STAGES] = !res_stall;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[0] = rdy[0] ? pix_valid : vld_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign pix_stall = !rdy[0];
    assign res_valid = vld_reg[S_OUT];

    // datapath registers
    pix_t       in_reg;
    div_t       tdiv_reg  [DIV_STEPS+1];
    tside_t     tside_reg [DIV_STEPS+1];
    div_t       tdiv_step [DIV_STEPS];
    tside_t     tside_nx  [DIV_STEPS];
    mix_t       mix_reg;
    div_lanes_t rdiv_reg  [DIV_STEPS+1];
    rside_t     rside_reg [DIV_STEPS+1];
    div_lanes_t rdiv_step [DIV_STEPS];
    rside_t     rside_nx  [DIV_STEPS];
    res_t       res_reg;

    // transmission set-up: num = 4*Ae - 3*d, dividend 255*num, divisor 4*Ae
    logic [9:0]  den_w;
    logic [9:0]  dark3_w;
    logic [9:0]  num_w;
    div_t        tdiv_first;
    tside_t      tside_first;

    always_comb
    begin
        den_w   = {est_air_reg, 2'b00};
        dark3_w = {2'b00, in_reg.dark_value} + {1'b0, in_reg.dark_value, 1'b0};
        num_w   = den_w - dark3_w;
        tdiv_first.rem = {num_w, 8'h00} - {8'h00, num_w};
        tdiv_first.quo = '0;
        tside_first.chans   = {in_reg.chan_two, in_reg.chan_one, in_reg.chan_zero};
        tside_first.ae_zero = est_air_reg == '0;
        tside_first.num_le0 = dark3_w >= den_w;
        tside_first.dsh     = {1'b0, den_w, 7'h00};
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_tdiv
        dhz_div_step u_step (
            .cur (tdiv_reg[j]),
            .dsh (tside_reg[j].dsh),
            .nxt (tdiv_step[j])
        );
        always_comb
        begin
            tside_nx[j]     = tside_reg[j];
            tside_nx[j].dsh = tside_reg[j].dsh >> 2;
        end
    end

    // transmission known: product As*t8 and channel differences
    logic [CH_W-1:0] t8_w;
    mix_t            mix_next;

    always_comb
    begin
        if (tside_reg[DIV_STEPS].ae_zero)
        begin
            t8_w = PIX_MAX;
        end
        else if (tside_reg[DIV_STEPS].num_le0)
        begin
            t8_w = '0;
        end
        else
        begin
            t8_w = tdiv_reg[DIV_STEPS].quo;
        end
        mix_next.t8   = t8_w;
        mix_next.prod = {8'h00, smooth_air_reg} * {8'h00, t8_w};
        for (int c = 0; c < NUM_CH; c++)
        begin
            mix_next.diff[c] = {1'b0, tside_reg[DIV_STEPS].chans[c]} - {1'b0, smooth_air_reg};
        end
    end

    // numerator |diff*255 + As*t8| and the low-transmission path
    logic signed [DIV_W-1:0] dx_w   [NUM_CH];
    logic signed [DIV_W-1:0] n_w    [NUM_CH];
    logic        [DIV_W-1:0] an_w   [NUM_CH];
    logic signed [12:0]      dx13_w [NUM_CH];
    logic signed [12:0]      v_w    [NUM_CH];
    logic        [12:0]      mag_w  [NUM_CH];
    div_lanes_t              rdiv_first;
    rside_t                  rside_first;

    always_comb
    begin
        rside_first.t8  = mix_reg.t8;
        rside_first.low = mix_reg.t8 <= LOW_T_MAX;
        rside_first.dsh = {3'b000, mix_reg.t8, 7'h00};
        for (int c = 0; c < NUM_CH; c++)
        begin
            dx_w[c]   = {{(DIV_W-CH_W-1){mix_reg.diff[c][CH_W]}}, mix_reg.diff[c]};
            n_w[c]    = (dx_w[c] <<< 8) - dx_w[c] + $signed({2'b00, mix_reg.prod});
            an_w[c]   = n_w[c][DIV_W-1] ? DIV_W'(-n_w[c]) : DIV_W'(n_w[c]);
            // quotient above 255 whenever |n| >= 256*t8
            rside_first.sat[c] = an_w[c] >= {2'b00, mix_reg.t8, 8'h00};
            rdiv_first[c].rem  = an_w[c];
            rdiv_first[c].quo  = '0;

            dx13_w[c] = {{(13-CH_W-1){mix_reg.diff[c][CH_W]}}, mix_reg.diff[c]};
            v_w[c]    = (dx13_w[c] <<< 3) + (dx13_w[c] <<< 1)
                        + $signed({5'b00000, smooth_air_reg});
            mag_w[c]  = v_w[c][12] ? 13'(-v_w[c]) : 13'(v_w[c]);
            rside_first.lowv[c] = (mag_w[c] > 13'd255) ? PIX_MAX : mag_w[c][CH_W-1:0];
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_rdiv
        for (genvar c = 0; c < NUM_CH; c++)
        begin : g_lane
            dhz_div_step u_step (
                .cur (rdiv_reg[j][c]),
                .dsh (rside_reg[j].dsh),
                .nxt (rdiv_step[j][c])
            );
        end
        always_comb
        begin
            rside_nx[j]     = rside_reg[j];
            rside_nx[j].dsh = rside_reg[j].dsh >> 2;
        end
    end

    // final selection
    logic [NUM_CH-1:0][CH_W-1:0] ch_out_w;
    res_t                        res_next;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (rside_reg[DIV_STEPS].low)
            begin
                ch_out_w[c] = rside_reg[DIV_STEPS].lowv[c];
            end
            else if (rside_reg[DIV_STEPS].sat[c])
            begin
                ch_out_w[c] = PIX_MAX;
            end
            else
            begin
                ch_out_w[c] = rdiv_reg[DIV_STEPS][c].quo;
            end
        end
        res_next.out_zero     = ch_out_w[0];
        res_next.out_one      = ch_out_w[1];
        res_next.out_two      = ch_out_w[2];
        res_next.transmission = rside_reg[DIV_STEPS].t8;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            in_reg <= pix;
        end
        if (rdy[S_TDIV])
        begin
            tdiv_reg[0]  <= tdiv_first;
            tside_reg[0] <= tside_first;
        end
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            if (rdy[S_TDIV+1+j])
            begin
                tdiv_reg[j+1]  <= tdiv_step[j];
                tside_reg[j+1] <= tside_nx[j];
            end
        end
        if (rdy[S_MIX])
        begin
            mix_reg <= mix_next;
        end
        if (rdy[S_RDIV])
        begin
            rdiv_reg[0]  <= rdiv_first;
            rside_reg[0] <= rside_first;
        end
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            if (rdy[S_RDIV+1+j])
            begin
                rdiv_reg[j+1]  <= rdiv_step[j];
                rside_reg[j+1] <= rside_nx[j];
            end
        end
        if (rdy[S_OUT])
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/core/dhz_div_step.sv =====
module dhz_div_step (
    input  dhz_pkg::div_t              cur,
    input  logic [dhz_pkg::DIV_W-1:0]  dsh,
    output dhz_pkg::div_t              nxt
);
    import dhz_pkg::*;

    logic             hi_bit;
    logic             lo_bit;
    logic [DIV_W-1:0] rem_mid;
    logic [DIV_W-1:0] dsh_lo;

    // two restoring steps; dsh is the divisor aligned to the higher bit
    always_comb
    begin
        dsh_lo  = dsh >> 1;
        hi_bit  = cur.rem >= dsh;
        rem_mid = hi_bit ? (cur.rem - dsh) : cur.rem;
        lo_bit  = rem_mid >= dsh_lo;
        nxt.rem = lo_bit ? (rem_mid - dsh_lo) : rem_mid;
        nxt.quo = {cur.quo[QUO_W-3:0], hi_bit, lo_bit};
    end

endmodule

// ===== rtl/core/dhz_checker.sv =====
module dhz_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          pix_stall,
    input logic          res_valid,
    input logic          res_stall,
    input dhz_pkg::res_t res
);

    // a held result stays put until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed or dropped while stalled");

    // input is only held off when the whole pipe is backed up from the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> res_valid && res_stall)
        else $error("input stalled with output free");

    // reset empties the pipe
    a_rst_empty: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result valid during reset");

endmodule

bind dehaze_pixel_recovery dhz_checker u_dhz_checker (.*);
